// File: rtl/qrs_pkg.sv
// shared widths, payload types and result kind codes of the quadratic root solver
package qrs_pkg;

    localparam int COEF_WIDTH  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 48;
    localparam int KIND_WIDTH  = 3;

    // discriminant, signed, and its magnitude
    localparam int DISC_WIDTH  = 2 * COEF_WIDTH + 2;
    // root bits from the square root chain
    localparam int ROOT_WIDTH  = COEF_WIDTH + 1 + FRAC_BITS;
    localparam int RAD_WIDTH   = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH   = ROOT_WIDTH + 2;
    // dividend magnitude, signed numerator and divisor magnitude
    localparam int NUM_WIDTH   = COEF_WIDTH + FRAC_BITS + 2;
    localparam int NUMS_WIDTH  = NUM_WIDTH + 1;
    localparam int DEN_WIDTH   = COEF_WIDTH + 1;

    localparam int SQ_CELLS    = ROOT_WIDTH;
    localparam int DIV_CELLS   = NUM_WIDTH;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_TWO_REAL   = 3'd0,
        KIND_DOUBLE     = 3'd1,
        KIND_COMPLEX    = 3'd2,
        KIND_LINEAR     = 3'd3,
        KIND_DEGENERATE = 3'd4
    } t_kind;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] c;
        logic                         dneg;
        logic                         dzero;
        logic [RAD_WIDTH-1:0]         rad;
        logic [REM_WIDTH-1:0]         rem;
        logic [ROOT_WIDTH-1:0]        root;
    } t_sq;

    typedef struct packed {
        t_kind                kind;
        logic [DEN_WIDTH-1:0] dmag;
        logic [NUM_WIDTH-1:0] n1;
        logic [NUM_WIDTH-1:0] n2;
        logic [DEN_WIDTH-1:0] r1;
        logic [DEN_WIDTH-1:0] r2;
        logic [NUM_WIDTH-1:0] q1;
        logic [NUM_WIDTH-1:0] q2;
        logic                 neg1;
        logic                 neg2;
    } t_dv;

endpackage

// File: rtl/qrs_if.sv
// valid/ready channels for coefficient beats and root beats
interface qrs_in_if;
    import qrs_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
    import qrs_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         root_kind;
    logic signed [VALUE_WIDTH-1:0] first_value;
    logic signed [VALUE_WIDTH-1:0] second_value;
    modport source (output valid, output root_kind, output first_value, output second_value,
                    input ready);
    modport sink (input valid, input root_kind, input first_value, input second_value,
                  output ready);
endinterface

// File: rtl/qrs_sqrt_cell.sv
// one root bit of the digit-by-digit square root, registered
module qrs_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qrs_pkg::t_sq  i_sq,
    output logic          o_valid,
    output qrs_pkg::t_sq  o_sq
);
    import qrs_pkg::*;

    logic [REM_WIDTH+1:0] w_cur;
    logic [REM_WIDTH+1:0] w_trial;
    t_sq                  n_sq;
    logic                 r_valid;
    t_sq                  r_sq;

    always_comb begin
        w_cur   = {i_sq.rem, i_sq.rad[RAD_WIDTH-1 -: 2]};
        w_trial = {1'b0, i_sq.root, 2'b01};
        n_sq     = i_sq;
        n_sq.rad = {i_sq.rad[RAD_WIDTH-3:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_sq.rem  = REM_WIDTH'(w_cur - w_trial);
            n_sq.root = {i_sq.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            n_sq.rem  = REM_WIDTH'(w_cur);
            n_sq.root = {i_sq.root[ROOT_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
endmodule

// File: rtl/qrs_div_cell.sv
// one quotient bit of two restoring divisions sharing a divisor, registered
module qrs_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qrs_pkg::t_dv  i_dv,
    output logic          o_valid,
    output qrs_pkg::t_dv  o_dv
);
    import qrs_pkg::*;

    logic [DEN_WIDTH:0] w_t1;
    logic [DEN_WIDTH:0] w_t2;
    logic [DEN_WIDTH:0] w_d;
    t_dv                n_dv;
    logic               r_valid;
    t_dv                r_dv;

    always_comb begin
        w_t1 = {i_dv.r1, i_dv.n1[NUM_WIDTH-1]};
        w_t2 = {i_dv.r2, i_dv.n2[NUM_WIDTH-1]};
        w_d  = {1'b0, i_dv.dmag};
        n_dv    = i_dv;
        n_dv.n1 = {i_dv.n1[NUM_WIDTH-2:0], 1'b0};
        n_dv.n2 = {i_dv.n2[NUM_WIDTH-2:0], 1'b0};
        if (w_t1 >= w_d) begin
            n_dv.r1 = DEN_WIDTH'(w_t1 - w_d);
            n_dv.q1 = {i_dv.q1[NUM_WIDTH-2:0], 1'b1};
        end else begin
            n_dv.r1 = DEN_WIDTH'(w_t1);
            n_dv.q1 = {i_dv.q1[NUM_WIDTH-2:0], 1'b0};
        end
        if (w_t2 >= w_d) begin
            n_dv.r2 = DEN_WIDTH'(w_t2 - w_d);
            n_dv.q2 = {i_dv.q2[NUM_WIDTH-2:0], 1'b1};
        end else begin
            n_dv.r2 = DEN_WIDTH'(w_t2);
            n_dv.q2 = {i_dv.q2[NUM_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_valid = r_valid;
    assign o_dv    = r_dv;
endmodule

// File: rtl/quadratic_root_solver_top.sv
// quadratic root solver: products, discriminant, square root chain, divider chain
//
//  channel | dir | beat contents
//  i_in    | in  | coef_a, coef_b, coef_c (signed integers)
//  o_out   | out | root_kind, first_value, second_value (signed fixed point)
//
// one beat accepted per cycle while the pipeline advances; stages in order: products,
// discriminant, 33 square root cells, numerator setup, 34 divider cells, output register
// the whole pipeline advances whenever the output register is empty or taken
// synchronous active-low reset clears every stage valid bit
module quadratic_root_solver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_in_if.sink     i_in,
    qrs_out_if.source  o_out
);
    import qrs_pkg::*;

    logic w_en;

    // products
    logic                           r1_valid;
    logic signed [COEF_WIDTH-1:0]   r1_a, r1_b, r1_c;
    logic signed [2*COEF_WIDTH-1:0] r1_bb, r1_ac;

    // discriminant
    logic signed [DISC_WIDTH-1:0] w_d;
    logic [DISC_WIDTH-1:0]        w_dmag;
    t_sq                          n_sq0;

    logic v_sq [0:SQ_CELLS];
    t_sq  sq   [0:SQ_CELLS];

    // numerator setup
    t_sq                          w_sqe;
    logic signed [NUMS_WIDTH-1:0] w_nb, w_s, w_lin, w_num1, w_num2, w_m1, w_m2;
    logic signed [DEN_WIDTH-1:0]  w_den;
    logic [DEN_WIDTH-1:0]         w_dmag_den;
    t_kind                        w_kind;
    t_dv                          n_dv0;

    logic v_dv [0:DIV_CELLS];
    t_dv  dv   [0:DIV_CELLS];

    // output
    t_dv                           w_dve;
    logic signed [NUMS_WIDTH-1:0]  w_q1, w_q2;
    logic                          r_ov;
    logic [KIND_WIDTH-1:0]         r_kind;
    logic signed [VALUE_WIDTH-1:0] r_v1, r_v2;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in.valid;
        end
        if (w_en) begin
            r1_a  <= i_in.coef_a;
            r1_b  <= i_in.coef_b;
            r1_c  <= i_in.coef_c;
            r1_bb <= i_in.coef_b * i_in.coef_b;
            r1_ac <= i_in.coef_a * i_in.coef_c;
        end
    end

    always_comb begin
        w_d    = DISC_WIDTH'(r1_bb) - (DISC_WIDTH'(r1_ac) <<< 2);
        w_dmag = w_d[DISC_WIDTH-1] ? DISC_WIDTH'(-w_d) : DISC_WIDTH'(w_d);
        n_sq0.a     = r1_a;
        n_sq0.b     = r1_b;
        n_sq0.c     = r1_c;
        n_sq0.dneg  = w_d[DISC_WIDTH-1];
        n_sq0.dzero = (w_d == '0);
        n_sq0.rad   = {w_dmag, {(RAD_WIDTH-DISC_WIDTH){1'b0}}};
        n_sq0.rem   = '0;
        n_sq0.root  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_sq[0] <= 1'b0;
        end else if (w_en) begin
            v_sq[0] <= r1_valid;
        end
        if (w_en) begin
            sq[0] <= n_sq0;
        end
    end

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (v_sq[g]),
            .i_sq    (sq[g]),
            .o_valid (v_sq[g+1]),
            .o_sq    (sq[g+1])
        );
    end

    always_comb begin
        w_sqe = sq[SQ_CELLS];
        w_nb  = -(NUMS_WIDTH'(w_sqe.b) <<< FRAC_BITS);
        w_lin = -(NUMS_WIDTH'(w_sqe.c) <<< FRAC_BITS);
        w_s   = NUMS_WIDTH'({1'b0, w_sqe.root});
        w_den = DEN_WIDTH'(w_sqe.a) <<< 1;
        if (w_sqe.a == '0) begin
            if (w_sqe.b == '0) begin
                w_kind = KIND_DEGENERATE;
                w_num1 = '0;
                w_num2 = '0;
                w_den  = DEN_WIDTH'(1);
            end else begin
                w_kind = KIND_LINEAR;
                w_num1 = w_lin;
                w_num2 = '0;
                w_den  = DEN_WIDTH'(w_sqe.b);
            end
        end else if (w_sqe.dzero) begin
            w_kind = KIND_DOUBLE;
            w_num1 = w_nb;
            w_num2 = w_nb;
        end else if (w_sqe.dneg) begin
            // imaginary part takes the sign of a so the quotient comes out positive
            w_kind = KIND_COMPLEX;
            w_num1 = w_nb;
            w_num2 = w_sqe.a[COEF_WIDTH-1] ? -w_s : w_s;
        end else begin
            w_kind = KIND_TWO_REAL;
            w_num1 = w_nb + w_s;
            w_num2 = w_nb - w_s;
        end
        w_m1       = w_num1[NUMS_WIDTH-1] ? -w_num1 : w_num1;
        w_m2       = w_num2[NUMS_WIDTH-1] ? -w_num2 : w_num2;
        w_dmag_den = w_den[DEN_WIDTH-1] ? DEN_WIDTH'(-w_den) : DEN_WIDTH'(w_den);
        n_dv0.kind = w_kind;
        n_dv0.dmag = w_dmag_den;
        n_dv0.n1   = w_m1[NUM_WIDTH-1:0];
        n_dv0.n2   = w_m2[NUM_WIDTH-1:0];
        n_dv0.r1   = '0;
        n_dv0.r2   = '0;
        n_dv0.q1   = '0;
        n_dv0.q2   = '0;
        n_dv0.neg1 = w_num1[NUMS_WIDTH-1] ^ w_den[DEN_WIDTH-1];
        n_dv0.neg2 = w_num2[NUMS_WIDTH-1] ^ w_den[DEN_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v_dv[0] <= 1'b0;
        end else if (w_en) begin
            v_dv[0] <= v_sq[SQ_CELLS];
        end
        if (w_en) begin
            dv[0] <= n_dv0;
        end
    end

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_dv
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (v_dv[g]),
            .i_dv    (dv[g]),
            .o_valid (v_dv[g+1]),
            .o_dv    (dv[g+1])
        );
    end

    always_comb begin
        w_dve = dv[DIV_CELLS];
        w_q1  = NUMS_WIDTH'({1'b0, w_dve.q1});
        w_q2  = NUMS_WIDTH'({1'b0, w_dve.q2});
        if (w_dve.neg1) begin
            w_q1 = -w_q1;
        end
        if (w_dve.neg2) begin
            w_q2 = -w_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= v_dv[DIV_CELLS];
        end
        if (w_en) begin
            r_kind <= w_dve.kind;
            r_v1   <= VALUE_WIDTH'(w_q1);
            r_v2   <= VALUE_WIDTH'(w_q2);
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.root_kind    = r_kind;
    assign o_out.first_value  = r_v1;
    assign o_out.second_value = r_v2;
endmodule

// File: test/quadratic_root_solver_top_test.sv
// testbench for the quadratic root solver: random and directed equations, scoreboard check
module quadratic_root_solver_top_test;
    import qrs_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct {
        t_kind                         kind;
        logic signed [VALUE_WIDTH-1:0] first;
        logic signed [VALUE_WIDTH-1:0] second;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors = 0;

    qrs_in_if  coef_ch ();
    qrs_out_if root_ch ();

    quadratic_root_solver_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (coef_ch.sink),
        .o_out   (root_ch.source)
    );

    always #1 i_clk = ~i_clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // floor(sqrt(mag) * 2^FRAC_BITS) by bit-serial restoring root
    // bit pairs below the fraction point are zero, so mag is never shifted up
    function automatic longint unsigned fixed_root(input longint unsigned mag);
        longint unsigned rem, root, trial, bits;
        rem = 0;
        root = 0;
        for (int i = ROOT_WIDTH - 1; i >= 0; i--) begin
            bits = 0;
            if (2 * i >= 2 * FRAC_BITS)
                bits = (mag >> (2 * i - 2 * FRAC_BITS)) & 2'b11;
            rem = (rem << 2) | bits;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic t_roots solve_roots(input logic signed [COEF_WIDTH-1:0] ca,
                                           input logic signed [COEF_WIDTH-1:0] cb,
                                           input logic signed [COEF_WIDTH-1:0] cc);
        t_roots r;
        longint a, b, c, disc, s, nb, den;
        a = ca;
        b = cb;
        c = cc;
        r.first = '0;
        r.second = '0;
        if (a == 0) begin
            if (b == 0) begin
                r.kind = KIND_DEGENERATE;
            end else begin
                r.kind = KIND_LINEAR;
                r.first = VALUE_WIDTH'(((-c) <<< FRAC_BITS) / b);
            end
        end else begin
            disc = b * b - 4 * a * c;
            nb = (-b) <<< FRAC_BITS;
            den = 2 * a;
            if (disc > 0) begin
                s = longint'(fixed_root(disc));
                r.kind = KIND_TWO_REAL;
                r.first = VALUE_WIDTH'((nb + s) / den);
                r.second = VALUE_WIDTH'((nb - s) / den);
            end else if (disc == 0) begin
                r.kind = KIND_DOUBLE;
                r.first = VALUE_WIDTH'(nb / den);
                r.second = r.first;
            end else begin
                s = longint'(fixed_root(-disc));
                r.kind = KIND_COMPLEX;
                r.first = VALUE_WIDTH'(nb / den);
                r.second = VALUE_WIDTH'(s / (den < 0 ? -den : den));
            end
        end
        return r;
    endfunction

    class root_scoreboard;
        t_roots pending[$];
        int     checked = 0;
        int     kind_seen[5] = '{0, 0, 0, 0, 0};

        function void note_equation(logic signed [COEF_WIDTH-1:0] a,
                                    logic signed [COEF_WIDTH-1:0] b,
                                    logic signed [COEF_WIDTH-1:0] c);
            pending.push_back(solve_roots(a, b, c));
        endfunction

        task check_roots(logic [KIND_WIDTH-1:0] kind, logic signed [VALUE_WIDTH-1:0] v1,
                         logic signed [VALUE_WIDTH-1:0] v2);
            t_roots w;
            if (pending.size() == 0) begin
                report("unexpected beat kind", kind, -1);
                return;
            end
            w = pending.pop_front();
            checked++;
            if (kind <= KIND_DEGENERATE) kind_seen[kind]++;
            if (kind != w.kind) report("root_kind", kind, w.kind);
            if (v1 != w.first) report("first_value", v1, w.first);
            if (v2 != w.second) report("second_value", v2, w.second);
        endtask
    endclass

    root_scoreboard sb = new();

    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_off = 0;
    int  quiet = 0;

    initial begin
        coef_ch.valid = 1'b0;
        coef_ch.coef_a = '0;
        coef_ch.coef_b = '0;
        coef_ch.coef_c = '0;
        root_ch.ready = 1'b0;
    end

    // receiver with random stalls and a long hold-off when asked
    always @(posedge i_clk) begin
        if (i_rst_n && root_ch.valid && root_ch.ready)
            sb.check_roots(root_ch.root_kind, root_ch.first_value, root_ch.second_value);
        root_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && coef_ch.valid && coef_ch.ready)
            sb.note_equation(coef_ch.coef_a, coef_ch.coef_b, coef_ch.coef_c);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("FAIL quadratic_root_solver_top");
            $finish;
        end
    end

    // valid stays high into the next beat unless the sender idles
    task automatic send_equation(input logic signed [COEF_WIDTH-1:0] a,
                                 input logic signed [COEF_WIDTH-1:0] b,
                                 input logic signed [COEF_WIDTH-1:0] c);
        while ($urandom_range(99) < send_idle) begin
            coef_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        coef_ch.valid <= 1'b1;
        coef_ch.coef_a <= a;
        coef_ch.coef_b <= b;
        coef_ch.coef_c <= c;
        @(posedge i_clk);
        while (!coef_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic signed [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3, 4: return COEF_WIDTH'($signed($urandom_range(16)) - 8);
            5, 6: return COEF_WIDTH'($signed($urandom_range(512)) - 256);
            default: return COEF_WIDTH'($urandom);
        endcase
    endfunction

    task automatic random_equation();
        logic signed [COEF_WIDTH-1:0] a, b, c, r1, r2;
        int mode;
        a = pick_coef();
        b = pick_coef();
        c = pick_coef();
        mode = $urandom_range(9);
        // steer toward double roots, linear and degenerate forms
        if (mode == 0) begin
            r1 = COEF_WIDTH'($signed($urandom_range(200)) - 100);
            r2 = COEF_WIDTH'($signed($urandom_range(6)) - 3);
            a = r2 == 0 ? 16'sd1 : r2;
            b = COEF_WIDTH'(-2 * a * r1);
            c = COEF_WIDTH'(a * r1 * r1);
            if (a * r1 * r1 > 32767 || a * r1 * r1 < -32768 || 2 * a * r1 > 32767
                || 2 * a * r1 < -32768) begin
                a = 16'sd1;
                b = COEF_WIDTH'(2 * r2);
                c = COEF_WIDTH'(r2 * r2);
            end
        end else if (mode == 1) begin
            a = '0;
        end else if (mode == 2 && $urandom_range(3) == 0) begin
            a = '0;
            b = '0;
        end
        send_equation(a, b, c);
    endtask

    task automatic wait_drained();
        coef_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and every kind of solution
        send_equation(16'sh7fff, 16'sh8000, 16'sh8000);
        send_equation(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_equation(16'sh8000, 16'sh8000, 16'sh8000);
        send_equation(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_equation(16'sh8000, 16'sh0000, 16'sh7fff);
        send_equation(16'sh7fff, 16'sh0000, 16'sh8000);
        send_equation(1, -3, 2);
        send_equation(1, 2, 1);
        send_equation(-1, 4, -4);
        send_equation(1, 0, 1);
        send_equation(-3, 1, -7);
        send_equation(2, 0, 0);
        send_equation(5, 7, 0);
        send_equation(0, 3, 7);
        send_equation(0, -3, 7);
        send_equation(0, 16'sh8000, 16'sh7fff);
        send_equation(0, 1, 16'sh8000);
        send_equation(0, 0, 16'sh7fff);
        send_equation(0, 0, 0);
        send_equation(16'shffff, 16'shffff, 16'shffff);
        send_equation(16'sh5555, 16'shaaaa, 16'sh5555);

        // pause until everything has drained
        wait_drained();

        send_idle = 32;
        recv_idle = 55;
        repeat (600) random_equation();

        // long receiver hold-off while coefficients keep coming
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (150) random_equation();
        join

        send_idle = 55;
        recv_idle = 32;
        repeat (550) random_equation();
        wait_drained();
        send_idle = 0;
        recv_idle = 0;
        repeat (550) random_equation();

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("checked %0d root beats: %0d two real, %0d double, %0d complex,",
                 sb.checked, sb.kind_seen[KIND_TWO_REAL], sb.kind_seen[KIND_DOUBLE],
                 sb.kind_seen[KIND_COMPLEX]);
        $display("%0d linear, %0d degenerate, under random and long stalls",
                 sb.kind_seen[KIND_LINEAR], sb.kind_seen[KIND_DEGENERATE]);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("PASS quadratic_root_solver_top");
        end else begin
            $display("FAIL quadratic_root_solver_top");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/qrs_pkg.sv
rtl/qrs_if.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_top.sv
test/quadratic_root_solver_top_test.sv
